/* rtl/core/clas_pkg.sv */
// Shared types and constants for the command line argument splitter.
// Item structs, output select and line status codes, character constants.
// No dependencies; every other file in rtl/core refers to this package.
`timescale 1ns / 1ps

package clas_pkg;

    // Character constants
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // Bounds: held backslash run and saturating argument count
    localparam int unsigned MAX_PENDING_BACKSLASH = 31;
    localparam int unsigned MAX_ARGS              = 255;
    localparam logic [4:0]  HOLD_LIMIT =
        5'((MAX_PENDING_BACKSLASH < 31) ? MAX_PENDING_BACKSLASH : 31);
    localparam logic [7:0]  TALLY_CAP  =
        8'((MAX_ARGS < 255) ? MAX_ARGS : 255);

    // Quote run reaches this count and emits one literal quote
    localparam logic [1:0]  QUOTE_TRIPLE_LAST = 2'd2;

    // Line status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;

    // Output register load select
    localparam logic [1:0] SEL_END  = 2'd0;   // end of argument, line goes on
    localparam logic [1:0] SEL_BSL  = 2'd1;   // one held backslash
    localparam logic [1:0] SEL_TAIL = 2'd2;   // captured character
    localparam logic [1:0] SEL_FIN  = 2'd3;   // last end mark of the line

    // Output kind codes
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_line;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_kind;
        logic       line_done;
        logic [7:0] arg_total;
        logic [1:0] status;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic       take;        // input item accepted this cycle
        logic       clear;       // line ends: capture final status, clear state
        logic       empty_line;  // line had no character
        logic       tally_up;    // a new argument begins
        logic       fresh;       // evaluate rules from a cleared argument state
        logic       arg_apply;   // commit the argument rule state
        logic       load;        // load the output register
        logic [1:0] sel;         // what to load
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic       eol;
        logic       blank;
        logic       quote;
        logic [4:0] a_nbs;       // backslashes to emit before the tail
        logic       a_tail;      // the character itself is emitted
        logic       a_gap;       // argument closed by a blank
        logic [4:0] pb;          // held backslash count
    } t_dp_sts;

endpackage

/* rtl/core/command_line_argument_splitter_core.sv */
// Command line argument splitter, top level.
// Depends on clas_pkg, clas_ctrl and clas_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes one command
//   line character per item, or an end-of-line item that closes the line.
//   Output channel (o_out_valid / i_out_stall / o_out_item) gives argument
//   characters and end-of-argument marks; the last result of a line has
//   line_done set with the argument count and the line status.
//   The results of an accepted item are queued in the controller's owed
//   result registers and then loaded into the output register in order.
//   Throughput: one item per cycle while each item causes at most one
//   result and the receiver does not stall. An item that causes k results
//   holds o_in_stall until its last result is loaded, since the output
//   register takes one result a cycle; a held backslash run flushed on its closing character gives up to 32.
//   When the receiver stalls, the output register holds its result and
//   the input stalls once the queued results of the current item are due.
//   Reset (synchronous, active low) clears the phase, the argument state,
//   the queued results and the output valid; a new line starts after it.
`timescale 1ns / 1ps

module command_line_argument_splitter_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  clas_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output clas_pkg::t_out_item o_out_item
);

    clas_pkg::t_dp_cmd dp_cmd;
    clas_pkg::t_dp_sts dp_sts;

    clas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    clas_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_out_item (o_out_item)
    );

endmodule

/* rtl/core/clas_dp.sv */
// Datapath of the argument splitter: character rules, argument state,
// argument tally, final status capture and the output register.
// Depends on clas_pkg; driven by clas_ctrl through t_dp_cmd.
`timescale 1ns / 1ps

module clas_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  clas_pkg::t_in_item  i_in_item,
    input  clas_pkg::t_dp_cmd   i_cmd,
    output clas_pkg::t_dp_sts   o_sts,
    output clas_pkg::t_out_item o_out_item
);

    logic [1:0] r_ql;
    logic [4:0] r_pb;
    logic       r_iqr;
    logic       r_ovf;
    logic [7:0] r_tally;
    logic [7:0] r_tail_byte;
    logic [7:0] r_fin_tally;
    logic [1:0] r_fin_status;
    clas_pkg::t_out_item r_out;

    logic [1:0] n_ql;
    logic [4:0] n_pb;
    logic       n_iqr;
    logic       n_ovf;
    clas_pkg::t_out_item n_out;

    logic [7:0] c;
    logic       is_q;
    logic       is_bs;
    logic       is_bl;
    logic [1:0] e_ql;
    logic [4:0] e_pb;
    logic       e_iqr;
    logic [4:0] a_nbs;
    logic       a_tail;
    logic       a_gap;

    // Character classes
    assign c     = i_in_item.in_byte;
    assign is_q  = (c == clas_pkg::CH_QUOTE);
    assign is_bs = (c == clas_pkg::CH_BSLASH);
    assign is_bl = (c == clas_pkg::CH_SPACE) || (c == clas_pkg::CH_TAB);

    // Rule inputs: a new argument starts from cleared state
    assign e_ql  = i_cmd.fresh ? 2'd0 : r_ql;
    assign e_pb  = i_cmd.fresh ? 5'd0 : r_pb;
    assign e_iqr = i_cmd.fresh ? 1'b0 : r_iqr;

    // Backslash halving and quote run rules for one character
    always_comb begin
        logic [1:0] ql_e;
        ql_e   = e_ql;
        n_ql   = e_ql;
        n_pb   = e_pb;
        n_iqr  = e_iqr;
        n_ovf  = r_ovf;
        a_nbs  = 5'd0;
        a_tail = 1'b0;
        a_gap  = 1'b0;
        if (e_iqr && is_q) begin
            // quote run goes on; the third quote is literal
            if (e_ql == clas_pkg::QUOTE_TRIPLE_LAST) begin
                a_tail = 1'b1;
                n_ql   = 2'd0;
            end else begin
                n_ql = e_ql + 2'd1;
            end
        end else begin
            // quote run ends; a pair closes back to unquoted
            if (e_iqr && (e_ql == clas_pkg::QUOTE_TRIPLE_LAST)) begin
                ql_e = 2'd0;
            end
            n_ql  = ql_e;
            n_iqr = 1'b0;
            if (is_bl && (ql_e == 2'd0)) begin
                a_nbs = e_pb;
                n_pb  = 5'd0;
                a_gap = 1'b1;
            end else if (is_bs) begin
                if (e_pb >= clas_pkg::HOLD_LIMIT) begin
                    a_tail = 1'b1;
                    n_ovf  = 1'b1;
                end else begin
                    n_pb = e_pb + 5'd1;
                end
            end else if (is_q) begin
                a_nbs = {1'b0, e_pb[4:1]};
                if (e_pb[0]) begin
                    a_tail = 1'b1;
                end else begin
                    n_ql = ql_e + 2'd1;
                end
                n_pb  = 5'd0;
                n_iqr = 1'b1;
            end else begin
                a_nbs  = e_pb;
                n_pb   = 5'd0;
                a_tail = 1'b1;
            end
        end
    end

    assign o_sts.eol    = i_in_item.end_of_line;
    assign o_sts.blank  = is_bl;
    assign o_sts.quote  = is_q;
    assign o_sts.a_nbs  = a_nbs;
    assign o_sts.a_tail = a_tail;
    assign o_sts.a_gap  = a_gap;
    assign o_sts.pb     = r_pb;

    // Argument state and tally
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ql    <= 2'd0;
            r_pb    <= 5'd0;
            r_iqr   <= 1'b0;
            r_ovf   <= 1'b0;
            r_tally <= 8'd0;
        end else if (i_cmd.take) begin
            if (i_cmd.clear) begin
                r_ql    <= 2'd0;
                r_pb    <= 5'd0;
                r_iqr   <= 1'b0;
                r_ovf   <= 1'b0;
                r_tally <= 8'd0;
            end else begin
                if (i_cmd.arg_apply) begin
                    r_ql  <= n_ql;
                    r_pb  <= n_pb;
                    r_iqr <= n_iqr;
                    r_ovf <= n_ovf;
                end
                if (i_cmd.tally_up && (r_tally < clas_pkg::TALLY_CAP)) begin
                    r_tally <= r_tally + 8'd1;
                end
            end
        end
    end

    // Captured payload for the queued results of the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_tail_byte <= c;
            if (i_cmd.clear) begin
                r_fin_tally <= r_tally;
                if (i_cmd.empty_line) begin
                    r_fin_status <= clas_pkg::ST_EMPTY;
                end else if (r_ovf) begin
                    r_fin_status <= clas_pkg::ST_OVER;
                end else begin
                    r_fin_status <= clas_pkg::ST_OK;
                end
            end
        end
    end

    // Next result from the load select
    always_comb begin
        n_out          = '0;
        n_out.out_kind = clas_pkg::KIND_END;
        n_out.status   = clas_pkg::ST_OK;
        case (i_cmd.sel)
            clas_pkg::SEL_END: begin
                n_out.out_kind = clas_pkg::KIND_END;
            end
            clas_pkg::SEL_BSL: begin
                n_out.out_byte = clas_pkg::CH_BSLASH;
                n_out.out_kind = clas_pkg::KIND_CHAR;
            end
            clas_pkg::SEL_TAIL: begin
                n_out.out_byte = r_tail_byte;
                n_out.out_kind = clas_pkg::KIND_CHAR;
            end
            clas_pkg::SEL_FIN: begin
                n_out.line_done = 1'b1;
                n_out.arg_total = r_fin_tally;
                n_out.status    = r_fin_status;
            end
            default: begin
                n_out.out_kind = clas_pkg::KIND_END;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= n_out;
        end
    end

    assign o_out_item = r_out;

endmodule

/* rtl/core/clas_ctrl.sv */
// Controller of the argument splitter: phase state machine, queue of
// results owed for the current item, handshakes and output valid.
// Depends on clas_pkg; commands clas_dp through t_dp_cmd.
`timescale 1ns / 1ps

module clas_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  clas_pkg::t_dp_sts i_sts,
    output clas_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] PH_AWAIT        = 3'd0;
    localparam logic [2:0] PH_FIRST_QUOTED = 3'd1;
    localparam logic [2:0] PH_FIRST_PLAIN  = 3'd2;
    localparam logic [2:0] PH_GAP          = 3'd3;
    localparam logic [2:0] PH_ARG          = 3'd4;

    logic [2:0] r_phase;
    logic [2:0] n_phase;
    logic       r_out_valid;

    // Results owed: lead end mark, backslashes, character, final end mark
    logic       r_lead;
    logic [4:0] r_cnt;
    logic       r_tail;
    logic       r_fin;
    logic       n_lead;
    logic [4:0] n_cnt;
    logic       n_tail;
    logic       n_fin;

    logic [5:0] remaining;
    logic       job_busy;
    logic       job_last;
    logic       slot_free;
    logic       emit;
    logic       take;
    logic       clear;
    logic       empty_line;
    logic       tally_up;
    logic       fresh;
    logic       arg_apply;
    logic [1:0] sel;

    // Queue occupancy and handshake
    assign remaining = {5'd0, r_lead} + {1'b0, r_cnt} + {5'd0, r_tail} + {5'd0, r_fin};
    assign job_busy  = (remaining != 6'd0);
    assign job_last  = (remaining == 6'd1);
    assign slot_free = !r_out_valid || !i_out_stall;
    assign emit      = job_busy && slot_free;
    assign o_in_stall = job_busy && !(job_last && slot_free);
    assign take      = i_in_valid && !o_in_stall;

    // Next result to load
    always_comb begin
        if (r_lead) begin
            sel = clas_pkg::SEL_END;
        end else if (r_cnt != 5'd0) begin
            sel = clas_pkg::SEL_BSL;
        end else if (r_tail) begin
            sel = clas_pkg::SEL_TAIL;
        end else begin
            sel = clas_pkg::SEL_FIN;
        end
    end

    // Phase decisions for the item at the input
    always_comb begin
        n_phase    = r_phase;
        n_lead     = 1'b0;
        n_cnt      = 5'd0;
        n_tail     = 1'b0;
        n_fin      = 1'b0;
        clear      = 1'b0;
        empty_line = 1'b0;
        tally_up   = 1'b0;
        fresh      = 1'b0;
        arg_apply  = 1'b0;
        case (r_phase)
            PH_AWAIT: begin
                if (i_sts.eol) begin
                    n_fin      = 1'b1;
                    clear      = 1'b1;
                    empty_line = 1'b1;
                end else begin
                    tally_up = 1'b1;
                    if (i_sts.quote) begin
                        n_phase = PH_FIRST_QUOTED;
                    end else if (i_sts.blank) begin
                        n_phase = PH_GAP;
                    end else begin
                        n_tail  = 1'b1;
                        n_phase = PH_FIRST_PLAIN;
                    end
                end
            end
            PH_FIRST_QUOTED: begin
                if (i_sts.eol) begin
                    n_fin   = 1'b1;
                    clear   = 1'b1;
                    n_phase = PH_AWAIT;
                end else if (i_sts.quote) begin
                    n_phase = PH_GAP;
                end else begin
                    n_tail = 1'b1;
                end
            end
            PH_FIRST_PLAIN: begin
                if (i_sts.eol) begin
                    n_fin   = 1'b1;
                    clear   = 1'b1;
                    n_phase = PH_AWAIT;
                end else if (i_sts.blank) begin
                    n_phase = PH_GAP;
                end else begin
                    n_tail = 1'b1;
                end
            end
            PH_GAP: begin
                if (i_sts.eol) begin
                    n_fin   = 1'b1;
                    clear   = 1'b1;
                    n_phase = PH_AWAIT;
                end else if (!i_sts.blank) begin
                    // close previous argument, open a new one
                    n_lead    = 1'b1;
                    tally_up  = 1'b1;
                    fresh     = 1'b1;
                    arg_apply = 1'b1;
                    n_cnt     = i_sts.a_nbs;
                    n_tail    = i_sts.a_tail;
                    n_phase   = PH_ARG;
                end
            end
            PH_ARG: begin
                if (i_sts.eol) begin
                    // held backslashes go out literally
                    n_cnt   = i_sts.pb;
                    n_fin   = 1'b1;
                    clear   = 1'b1;
                    n_phase = PH_AWAIT;
                end else begin
                    arg_apply = 1'b1;
                    n_cnt     = i_sts.a_nbs;
                    n_tail    = i_sts.a_tail;
                    if (i_sts.a_gap) begin
                        n_phase = PH_GAP;
                    end
                end
            end
            default: begin
                n_phase = PH_AWAIT;
            end
        endcase
    end

    // Phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_AWAIT;
        end else if (take) begin
            r_phase <= n_phase;
        end
    end

    // Owed results: reloaded on accept, drained one per load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= 1'b0;
            r_cnt  <= 5'd0;
            r_tail <= 1'b0;
            r_fin  <= 1'b0;
        end else if (take) begin
            r_lead <= n_lead;
            r_cnt  <= n_cnt;
            r_tail <= n_tail;
            r_fin  <= n_fin;
        end else if (emit) begin
            if (r_lead) begin
                r_lead <= 1'b0;
            end else if (r_cnt != 5'd0) begin
                r_cnt <= r_cnt - 5'd1;
            end else if (r_tail) begin
                r_tail <= 1'b0;
            end else begin
                r_fin <= 1'b0;
            end
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_cmd.take       = take;
    assign o_cmd.clear      = clear;
    assign o_cmd.empty_line = empty_line;
    assign o_cmd.tally_up   = tally_up;
    assign o_cmd.fresh      = fresh;
    assign o_cmd.arg_apply  = arg_apply;
    assign o_cmd.load       = emit;
    assign o_cmd.sel        = sel;

    // A line end always returns to the first-character phase
    a_eol_to_await: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_sts.eol) |=> (r_phase == PH_AWAIT))
        else $error("line end did not return to await phase");

    // An opening end mark never shares an item with the line's final mark
    a_lead_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_lead && r_fin))
        else $error("lead end mark and final end mark both owed");

    // A character result and a final end mark come from different items
    a_tail_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_tail && r_fin))
        else $error("character and final end mark both owed");

    // A new argument starts with no held backslashes
    a_lead_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lead |-> (r_cnt == 5'd0))
        else $error("backslashes owed behind an argument start");

endmodule

/* tb/tb_command_line_argument_splitter_core.sv */
// Self-checking testbench for command_line_argument_splitter_core.
// Drives command lines through the valid/stall channels and predicts the argument stream.
// Depends on clas_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_command_line_argument_splitter_core;

    // Line phases of the predictor
    typedef enum logic [2:0] {
        WAIT_FIRST,
        FIRST_QUOTED,
        FIRST_PLAIN,
        IN_GAP,
        IN_ARG
    } t_split_state;

    // Predicts the argument stream of each line and checks the results against it
    class argv_split_board;
        clas_pkg::t_out_item expected_q[$];
        int                  errors;
        t_split_state        state;
        logic [1:0]          quote_cnt;
        logic [4:0]          held_bs;
        logic                quote_run;
        logic [7:0]          arg_cnt;
        logic                overflow;

        function new();
            errors = 0;
            clear_line();
        endfunction

        function void clear_line();
            state     = WAIT_FIRST;
            quote_cnt = '0;
            held_bs   = '0;
            quote_run = 1'b0;
            arg_cnt   = '0;
            overflow  = 1'b0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return (c == clas_pkg::CH_SPACE) || (c == clas_pkg::CH_TAB);
        endfunction

        function void push_piece(logic [7:0] ch, logic kind);
            clas_pkg::t_out_item p;
            p          = '0;
            p.out_byte = ch;
            p.out_kind = kind;
            expected_q.push_back(p);
        endfunction

        // Last piece of the line carries the count and status
        function void close_line(logic [1:0] st);
            clas_pkg::t_out_item p;
            p           = expected_q.pop_back();
            p.line_done = 1'b1;
            p.arg_total = arg_cnt;
            p.status    = st;
            expected_q.push_back(p);
            clear_line();
        endfunction

        function void count_arg();
            if (arg_cnt < clas_pkg::TALLY_CAP)
                arg_cnt++;
        endfunction

        function void flush_held();
            repeat (held_bs) push_piece(clas_pkg::CH_BSLASH, clas_pkg::KIND_CHAR);
            held_bs = '0;
        endfunction

        function void close_quote_run();
            if (quote_run) begin
                if (quote_cnt == clas_pkg::QUOTE_TRIPLE_LAST)
                    quote_cnt = '0;
                quote_run = 1'b0;
            end
        endfunction

        // Backslash and quote rules of the later arguments
        function void arg_rule(logic [7:0] c);
            if (quote_run) begin
                if (c == clas_pkg::CH_QUOTE) begin
                    quote_cnt++;
                    if (quote_cnt > clas_pkg::QUOTE_TRIPLE_LAST) begin
                        push_piece(clas_pkg::CH_QUOTE, clas_pkg::KIND_CHAR);
                        quote_cnt = '0;
                    end
                    return;
                end
                close_quote_run();
            end
            if (is_blank(c) && quote_cnt == '0) begin
                flush_held();
                state = IN_GAP;
                return;
            end
            if (c == clas_pkg::CH_BSLASH) begin
                if (held_bs >= clas_pkg::HOLD_LIMIT) begin
                    push_piece(clas_pkg::CH_BSLASH, clas_pkg::KIND_CHAR);
                    overflow = 1'b1;
                end else begin
                    held_bs++;
                end
                return;
            end
            if (c == clas_pkg::CH_QUOTE) begin
                repeat (held_bs >> 1) push_piece(clas_pkg::CH_BSLASH, clas_pkg::KIND_CHAR);
                if (held_bs[0])
                    push_piece(clas_pkg::CH_QUOTE, clas_pkg::KIND_CHAR);
                else
                    quote_cnt++;
                held_bs   = '0;
                quote_run = 1'b1;
                return;
            end
            flush_held();
            push_piece(c, clas_pkg::KIND_CHAR);
        endfunction

        // Accepted input item: append the results it causes
        function void take_item(clas_pkg::t_in_item it);
            logic [7:0] c;
            logic       eol;
            logic [1:0] st;
            logic       closes;
            c      = it.in_byte;
            eol    = it.end_of_line;
            st     = overflow ? clas_pkg::ST_OVER : clas_pkg::ST_OK;
            closes = (state == FIRST_QUOTED) ? (c == clas_pkg::CH_QUOTE) : is_blank(c);
            case (state)
                WAIT_FIRST: begin
                    if (eol) begin
                        push_piece(8'h00, clas_pkg::KIND_END);
                        close_line(clas_pkg::ST_EMPTY);
                    end else begin
                        count_arg();
                        if (c == clas_pkg::CH_QUOTE) begin
                            state = FIRST_QUOTED;
                        end else if (is_blank(c)) begin
                            state = IN_GAP;
                        end else begin
                            push_piece(c, clas_pkg::KIND_CHAR);
                            state = FIRST_PLAIN;
                        end
                    end
                end
                FIRST_QUOTED, FIRST_PLAIN: begin
                    if (eol) begin
                        push_piece(8'h00, clas_pkg::KIND_END);
                        close_line(st);
                    end else if (closes) begin
                        state = IN_GAP;
                    end else begin
                        push_piece(c, clas_pkg::KIND_CHAR);
                    end
                end
                IN_GAP: begin
                    if (eol) begin
                        push_piece(8'h00, clas_pkg::KIND_END);
                        close_line(st);
                    end else if (!is_blank(c)) begin
                        push_piece(8'h00, clas_pkg::KIND_END);
                        count_arg();
                        state     = IN_ARG;
                        quote_cnt = '0;
                        held_bs   = '0;
                        quote_run = 1'b0;
                        arg_rule(c);
                    end
                end
                default: begin
                    if (eol) begin
                        close_quote_run();
                        flush_held();
                        push_piece(8'h00, clas_pkg::KIND_END);
                        close_line(st);
                    end else begin
                        arg_rule(c);
                    end
                end
            endcase
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        // Accepted result: compare with the oldest expectation
        function void check_piece(clas_pkg::t_out_item got);
            clas_pkg::t_out_item want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, expected none, got %p", $time, got);
                return;
            end
            want = expected_q.pop_front();
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("out_kind", 8'(want.out_kind), 8'(got.out_kind));
            check_field("line_done", 8'(want.line_done), 8'(got.line_done));
            check_field("arg_total", want.arg_total, got.arg_total);
            check_field("status", 8'(want.status), 8'(got.status));
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    clas_pkg::t_in_item  i_in_item   = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    clas_pkg::t_out_item o_out_item;

    argv_split_board board = new();
    int idle_pct   = 20;
    int sent_items = 0;
    int rx_count   = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    command_line_argument_splitter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // Offer one item, idling at random first, and wait until it is taken
    task automatic send_item(input clas_pkg::t_in_item it);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        board.take_item(it);
        sent_items++;
    endtask

    task automatic send_char(input logic [7:0] c);
        clas_pkg::t_in_item it;
        it.in_byte     = c;
        it.end_of_line = 1'b0;
        send_item(it);
    endtask

    // End of line; the byte is don't-care, so it is random
    task automatic send_eol();
        clas_pkg::t_in_item it;
        it.in_byte     = 8'($urandom_range(0, 255));
        it.end_of_line = 1'b1;
        send_item(it);
    endtask

    // Character mix weighted toward quotes, backslashes and blanks
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return clas_pkg::CH_QUOTE;
        if (r < 38) return clas_pkg::CH_BSLASH;
        if (r < 52) return clas_pkg::CH_SPACE;
        if (r < 58) return clas_pkg::CH_TAB;
        if (r < 82) return 8'($urandom_range(8'h61, 8'h7a));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_line();
        int kind;
        int len;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // long backslash run in a later argument, past the hold bound at times
            send_char(8'($urandom_range(8'h61, 8'h7a)));
            send_char(clas_pkg::CH_SPACE);
            repeat ($urandom_range(25, 40)) send_char(clas_pkg::CH_BSLASH);
            case ($urandom_range(0, 3))
                0: send_char(clas_pkg::CH_QUOTE);
                1: send_char(8'($urandom_range(8'h61, 8'h7a)));
                2: send_char(clas_pkg::CH_TAB);
                default: ;
            endcase
        end else begin
            len = (kind == 1) ? 0 : $urandom_range(1, 14);
            repeat (len) send_char(pick_char());
        end
        send_eol();
    endtask

    // Result side: check, then choose the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_piece(o_out_item);
            rx_count++;
        end
        if (!hold_done && rx_count == 30) begin
            hold_done = 1'b1;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (rx_count >= 150 && rx_count < 250) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < 20);
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty line
        send_eol();
        // quoted path with a blank inside, halved backslashes, triple quote
        send_char(clas_pkg::CH_QUOTE);
        send_char(8'h70);
        send_char(clas_pkg::CH_SPACE);
        send_char(clas_pkg::CH_QUOTE);
        send_char(clas_pkg::CH_SPACE);
        send_char(clas_pkg::CH_BSLASH);
        send_char(clas_pkg::CH_BSLASH);
        send_char(clas_pkg::CH_QUOTE);
        send_char(clas_pkg::CH_QUOTE);
        send_char(clas_pkg::CH_QUOTE);
        send_char(clas_pkg::CH_QUOTE);
        send_eol();
        // leading tab, zero and all-ones bytes, escaped quote
        send_char(clas_pkg::CH_TAB);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(clas_pkg::CH_BSLASH);
        send_char(clas_pkg::CH_QUOTE);
        send_eol();
        // single plain argument closed by the end of line
        send_char(8'h78);
        send_eol();

        // a line with many arguments; the receiver holds off meanwhile
        repeat (40) begin
            send_char(8'($urandom_range(8'h61, 8'h7a)));
            send_char($urandom_range(0, 1) ? clas_pkg::CH_SPACE : clas_pkg::CH_TAB);
        end
        send_eol();

        // random lines, with a stretch of back-to-back items
        while (sent_items < 330) begin
            idle_pct = (sent_items >= 150 && sent_items < 250) ? 0 : 20;
            send_random_line();
        end
        i_in_valid <= 1'b0;

        while (board.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/clas_pkg.sv
rtl/core/clas_dp.sv
rtl/core/clas_ctrl.sv
rtl/core/command_line_argument_splitter_core.sv
tb/tb_command_line_argument_splitter_core.sv
